@@ rtl/core/ifd_pkg.sv @@
`default_nettype none

package ifd_pkg;

	// field and register widths
	localparam int FIELD_W      = 32;
	localparam int REG_W        = 31;
	localparam int ACC_W        = 64;
	localparam int FRAC_BITS    = 16;
	localparam int NUM_REGS     = 5;
	localparam int CFG_IDX_W    = 3;
	localparam int DIR_W        = 3;
	localparam int OPND_W       = FIELD_W + 1;
	localparam int PROD_W       = 2 * OPND_W;
	localparam int IN_DATA_W    = 6 * FIELD_W;
	localparam int IN_USER_W    = DIR_W + 2;
	localparam int DATA_WIDTH_DEF = 32;

	// reset value of every register, 1.0 in unsigned Q15.16
	localparam logic [REG_W-1:0] REG_RESET = REG_W'(65536);

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSIVITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Z    = 3'd4;

	// face directions: codes at or above this carry no flux
	localparam logic [DIR_W-1:0] DIR_COUNT = 3'd6;

	// clip a wide signed value to a signed field
	function automatic logic signed [FIELD_W-1:0] clip_field(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(signed'(33'sh0_7FFF_FFFF));
		lo = PROD_W'(signed'(33'sh1_8000_0000));
		if (x > hi) begin
			clip_field = hi[FIELD_W-1:0];
		end else if (x < lo) begin
			clip_field = lo[FIELD_W-1:0];
		end else begin
			clip_field = x[FIELD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ion_flux_divergence_unit.sv @@
`default_nettype none

// Finite-volume Nernst-Planck flux divergence for one cell.
// Faces of a cell arrive on the s_axis channel, one transfer per face, tlast
// on the final face. Each open face forms the diffusion and drift fluxes of
// both charge species, scales them by the face axis factor and adds them to
// 64-bit accumulators. After the final face one result (both rates, clipped
// to DATA_WIDTH signed bits, plus a clip flag) leaves on m_axis.
// Registers (diffusivity, beta, factor_x/y/z) are written through the cfg
// channel, which is always ready; write them only while the block is idle.
// Sequencing: an open face takes nine products in turn on one shared 33x33
// multiplier, and the block takes no new face until the sequence and its
// drain state are done; a blocked face or an invalid direction starts no
// sequence. After the last face the finish state loads the output register.
// The output register holds a result while the receiver stalls and the
// next face is still taken; a further result waits in the finish state
// until the output register is free.
// Reset returns the registers to 1.0, clears both accumulators and drops
// m_axis_tvalid.
module ion_flux_divergence_unit #(
	parameter int DATA_WIDTH = ifd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration write channel
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [ifd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ifd_pkg::FIELD_W-1:0]            cfg_data,
	// face input channel
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// potential_center, potential_neighbor, pos_center, pos_neighbor,
	// neg_center, neg_neighbor
	input  wire logic [ifd_pkg::IN_DATA_W-1:0]          s_axis_tdata,
	// face_dir, face_blocked, in_material
	input  wire logic [ifd_pkg::IN_USER_W-1:0]          s_axis_tuser,
	input  wire logic                                   s_axis_tlast,
	// result output channel
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// pos_rate, neg_rate, zero padding
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
	// saturated
	output logic [0:0]                                  m_axis_tuser
);

	import ifd_pkg::*;

	localparam int OUT_DATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int PAD_W      = OUT_DATA_W - 2 * DATA_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		STEP_HDB,
		STEP_PDIFF,
		STEP_P1,
		STEP_NDIFF,
		STEP_N1,
		STEP_P2,
		STEP_N2,
		STEP_PSCALE,
		STEP_NSCALE
	} step_t;

	state_t state_q;
	step_t  step_q;
	step_t  wb_step_q;
	logic   wb_valid_q;

	logic [REG_W-1:0] regs_q [NUM_REGS];

	// face operands captured at the transfer
	logic signed [OPND_W-1:0] psum_q, pdelta_q, nsum_q, ndelta_q, de_q;
	logic [1:0]               axis_q;
	logic                     inmat_q;
	logic                     last_q;

	// intermediate results of the sequence
	logic signed [FIELD_W-1:0] hdb_q, pdiff_q, ndiff_q, p1_q, n1_q, pflux_q, nflux_q;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [ACC_W-1:0] pos_acc_q, neg_acc_q;

	logic [DATA_WIDTH-1:0] pos_rate_q, neg_rate_q;
	logic                  sat_q;
	logic                  out_valid_q;

	// input field views
	logic [DIR_W-1:0]           in_dir;
	logic                       in_blocked, in_inmat;
	logic signed [FIELD_W-1:0]  in_ec, in_en, in_pc, in_pn, in_nc, in_nn;
	logic                       in_xfer, in_open;

	assign in_dir     = s_axis_tuser[DIR_W-1:0];
	assign in_blocked = s_axis_tuser[DIR_W];
	assign in_inmat   = s_axis_tuser[DIR_W+1];
	assign in_ec      = s_axis_tdata[0*FIELD_W +: FIELD_W];
	assign in_en      = s_axis_tdata[1*FIELD_W +: FIELD_W];
	assign in_pc      = s_axis_tdata[2*FIELD_W +: FIELD_W];
	assign in_pn      = s_axis_tdata[3*FIELD_W +: FIELD_W];
	assign in_nc      = s_axis_tdata[4*FIELD_W +: FIELD_W];
	assign in_nn      = s_axis_tdata[5*FIELD_W +: FIELD_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_open       = !in_blocked && (in_dir < DIR_COUNT);
	assign cfg_ready     = 1'b1;

	// operand select for the shared multiplier
	logic signed [OPND_W-1:0] op_a, op_b;
	logic [REG_W-1:0]         fac;

	always_comb begin
		case (axis_q)
			2'd0:    fac = regs_q[REG_FACTOR_X];
			2'd1:    fac = regs_q[REG_FACTOR_Y];
			default: fac = regs_q[REG_FACTOR_Z];
		endcase
	end

	always_comb begin
		unique case (step_q)
			STEP_HDB: begin
				op_a = {2'b00, regs_q[REG_DIFFUSIVITY]};
				op_b = {2'b00, regs_q[REG_BETA]};
			end
			STEP_PDIFF: begin
				op_a = {2'b00, regs_q[REG_DIFFUSIVITY]};
				op_b = pdelta_q;
			end
			STEP_P1: begin
				op_a = {hdb_q[FIELD_W-1], hdb_q};
				op_b = psum_q;
			end
			STEP_NDIFF: begin
				op_a = {2'b00, regs_q[REG_DIFFUSIVITY]};
				op_b = ndelta_q;
			end
			STEP_N1: begin
				op_a = {hdb_q[FIELD_W-1], hdb_q};
				op_b = nsum_q;
			end
			STEP_P2: begin
				op_a = {p1_q[FIELD_W-1], p1_q};
				op_b = de_q;
			end
			STEP_N2: begin
				op_a = {n1_q[FIELD_W-1], n1_q};
				op_b = de_q;
			end
			STEP_PSCALE: begin
				op_a = {2'b00, fac};
				op_b = {pflux_q[FIELD_W-1], pflux_q};
			end
			STEP_NSCALE: begin
				op_a = {2'b00, fac};
				op_b = {nflux_q[FIELD_W-1], nflux_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	logic signed [PROD_W-1:0] mul_p;
	assign mul_p = op_a * op_b;

	// write-back of the registered product
	logic signed [PROD_W-1:0]  q_shift;
	logic signed [FIELD_W-1:0] q_clip;
	logic signed [OPND_W-1:0]  pflux_sum, nflux_sum;
	logic signed [ACC_W-1:0]   scaled;
	logic signed [ACC_W-1:0]   acc_sel;
	logic signed [ACC_W:0]     acc_sum;
	logic signed [ACC_W-1:0]   acc_next;

	assign q_shift   = (wb_step_q == STEP_HDB) ? (prod_q >>> (FRAC_BITS + 1))
	                                           : (prod_q >>> FRAC_BITS);
	assign q_clip    = clip_field(q_shift);
	assign pflux_sum = {pdiff_q[FIELD_W-1], pdiff_q} + {q_clip[FIELD_W-1], q_clip};
	assign nflux_sum = {ndiff_q[FIELD_W-1], ndiff_q} - {q_clip[FIELD_W-1], q_clip};
	assign scaled    = q_shift[ACC_W-1:0];
	assign acc_sel   = (wb_step_q == STEP_PSCALE) ? pos_acc_q : neg_acc_q;
	assign acc_sum   = {acc_sel[ACC_W-1], acc_sel} + {scaled[ACC_W-1], scaled};

	// accumulate with saturation at the 64-bit limits
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
	end

	// final clip of the rates to DATA_WIDTH bits
	logic [ACC_W-DATA_WIDTH:0] pos_top, neg_top;
	logic                      pos_fits, neg_fits;
	logic [DATA_WIDTH-1:0]     pos_clip, neg_clip;
	logic                      out_free;

	assign pos_top  = pos_acc_q[ACC_W-1:DATA_WIDTH-1];
	assign neg_top  = neg_acc_q[ACC_W-1:DATA_WIDTH-1];
	assign pos_fits = (&pos_top) || !(|pos_top);
	assign neg_fits = (&neg_top) || !(|neg_top);
	assign pos_clip = pos_fits ? pos_acc_q[DATA_WIDTH-1:0] :
	                  (pos_acc_q[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
	                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}});
	assign neg_clip = neg_fits ? neg_acc_q[DATA_WIDTH-1:0] :
	                  (neg_acc_q[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
	                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}});
	assign out_free = !out_valid_q || m_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIFFUSIVITY: regs_q[REG_DIFFUSIVITY] <= cfg_data[REG_W-1:0];
				REG_BETA:        regs_q[REG_BETA]        <= cfg_data[REG_W-1:0];
				REG_FACTOR_X:    regs_q[REG_FACTOR_X]    <= cfg_data[REG_W-1:0];
				REG_FACTOR_Y:    regs_q[REG_FACTOR_Y]    <= cfg_data[REG_W-1:0];
				REG_FACTOR_Z:    regs_q[REG_FACTOR_Z]    <= cfg_data[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// capture face operands on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			psum_q   <= {in_pn[FIELD_W-1], in_pn} + {in_pc[FIELD_W-1], in_pc};
			pdelta_q <= {in_pn[FIELD_W-1], in_pn} - {in_pc[FIELD_W-1], in_pc};
			nsum_q   <= {in_nn[FIELD_W-1], in_nn} + {in_nc[FIELD_W-1], in_nc};
			ndelta_q <= {in_nn[FIELD_W-1], in_nn} - {in_nc[FIELD_W-1], in_nc};
			de_q     <= {in_en[FIELD_W-1], in_en} - {in_ec[FIELD_W-1], in_ec};
			axis_q   <= in_dir[DIR_W-1:1];
			inmat_q  <= in_inmat;
			last_q   <= s_axis_tlast;
		end
	end

	// shared multiplier and intermediate results
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			prod_q <= mul_p;
		end
		if (wb_valid_q) begin
			case (wb_step_q)
				STEP_HDB:   hdb_q   <= q_clip;
				STEP_PDIFF: pdiff_q <= q_clip;
				STEP_P1:    p1_q    <= q_clip;
				STEP_NDIFF: ndiff_q <= q_clip;
				STEP_N1:    n1_q    <= q_clip;
				STEP_P2:    pflux_q <= clip_field(PROD_W'(pflux_sum));
				STEP_N2:    nflux_q <= clip_field(PROD_W'(nflux_sum));
				default: ;
			endcase
		end
	end

	// sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_HDB;
			wb_step_q   <= STEP_HDB;
			wb_valid_q  <= 1'b0;
			pos_acc_q   <= '0;
			neg_acc_q   <= '0;
			out_valid_q <= 1'b0;
			pos_rate_q  <= '0;
			neg_rate_q  <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// accumulate scaled fluxes
			if (wb_valid_q && (wb_step_q == STEP_PSCALE)) begin
				pos_acc_q <= acc_next;
			end
			if (wb_valid_q && (wb_step_q == STEP_NSCALE)) begin
				neg_acc_q <= acc_next;
			end

			unique case (state_q)
				ST_IDLE: begin
					wb_valid_q <= 1'b0;
					if (in_xfer) begin
						step_q <= STEP_HDB;
						if (in_open) begin
							state_q <= ST_RUN;
						end else if (s_axis_tlast) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_RUN: begin
					wb_step_q  <= step_q;
					wb_valid_q <= 1'b1;
					if (step_q == STEP_NSCALE) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				ST_DRAIN: begin
					wb_valid_q <= 1'b0;
					state_q    <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pos_rate_q  <= inmat_q ? pos_clip : '0;
						neg_rate_q  <= inmat_q ? neg_clip : '0;
						sat_q       <= inmat_q && (!pos_fits || !neg_fits);
						pos_acc_q   <= '0;
						neg_acc_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, neg_rate_q, pos_rate_q};
	assign m_axis_tuser  = sat_q;

	// no product is in flight while a face can be taken
	a_idle_no_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !wb_valid_q)
		else $error("writeback pending while input ready");

	// a face without flux that is not the last leaves the accumulators alone
	a_closed_face_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !in_open && !s_axis_tlast) |=> ($stable(pos_acc_q) && $stable(neg_acc_q)))
		else $error("closed face changed an accumulator");

	// loading a result clears the accumulators
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=>
			(m_axis_tvalid && pos_acc_q == '0 && neg_acc_q == '0 && state_q == ST_IDLE))
		else $error("result load did not clear accumulators");

	// a cell outside the material gives zero rates and no clip flag
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free && !inmat_q) |=>
			(m_axis_tdata == '0 && m_axis_tuser == 1'b0))
		else $error("non-material cell gave non-zero result");

endmodule

`default_nettype wire

@@ tb/sv/tb_ion_flux_divergence_unit.sv @@
module tb_ion_flux_divergence_unit;
	import ifd_pkg::*;

	localparam int     CLK_PERIOD    = 12;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     SETTLE_CYCLES = 24;
	localparam int     DRAIN_LIMIT   = 60000;
	localparam int     RUN_LIMIT     = 700000;
	localparam int     NUM_PHASES    = 8;
	localparam int     PHASE_FACES   = 205;
	localparam longint MID_MAX       = 64'sd2147483647;
	localparam longint MID_MIN       = -64'sd2147483648;
	localparam longint ACC_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN       = 64'sh8000_0000_0000_0000;

	typedef enum logic [DIR_W-1:0] {
		FACE_XP, FACE_XN, FACE_YP, FACE_YN, FACE_ZP, FACE_ZN, FACE_BAD6, FACE_BAD7
	} face_dir_e;

	typedef struct packed {
		face_dir_e          dir;
		logic               blocked;
		logic               in_mat;
		logic               last;
		logic signed [31:0] pot_c;
		logic signed [31:0] pot_n;
		logic signed [31:0] pos_c;
		logic signed [31:0] pos_n;
		logic signed [31:0] neg_c;
		logic signed [31:0] neg_n;
	} face_t;

	typedef struct packed {
		logic signed [31:0] pos_rate;
		logic signed [31:0] neg_rate;
		logic               sat;
	} rates_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [FIELD_W-1:0]   cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
	logic [IN_USER_W-1:0] s_axis_tuser  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [63:0]          m_axis_tdata;
	logic [0:0]           m_axis_tuser;

	// faces waiting to be sent, the face on the bus, rates still to come
	face_t  faces_q[$];
	face_t  cur_face;
	rates_t rates_q[$];
	rates_t head_rates;

	// shadow registers and accumulators of the flux model
	longint coef[NUM_REGS];
	longint pos_acc;
	longint neg_acc;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_arm       = 1'b0;
	bit hold_done      = 1'b0;
	int hold_count     = 0;
	int errors         = 0;

	int send_pcts[NUM_PHASES] = '{69, 0, 14, 0, 69, 0, 14, 0};
	int recv_pcts[NUM_PHASES] = '{0, 69, 14, 0, 0, 69, 14, 0};

	ion_flux_divergence_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// signed 32-bit clip of intermediate terms
	function automatic longint clip_mid(input longint x);
		if (x > MID_MAX) return MID_MAX;
		if (x < MID_MIN) return MID_MIN;
		return x;
	endfunction

	// Q16.16 product, floored, clipped to 32 bits
	function automatic longint qmul(input longint a, input longint b);
		return clip_mid((a * b) >>> FRAC_BITS);
	endfunction

	// accumulate with saturation at the 64-bit limits
	function automatic longint acc_add(input longint acc, input longint x);
		longint s;
		s = acc + x;
		if (x > 0 && s < acc) return ACC_MAX;
		if (x < 0 && s > acc) return ACC_MIN;
		return s;
	endfunction

	// fold one face into the accumulators, queue the rates on the last face
	task automatic accumulate_face(input face_t f);
		longint de, hdb, fac, pdrift, ndrift, pflux, nflux, pr, nr;
		rates_t r;
		if (!f.blocked && f.dir < DIR_COUNT) begin
			de     = longint'(f.pot_n) - longint'(f.pot_c);
			hdb    = clip_mid((coef[REG_DIFFUSIVITY] * coef[REG_BETA]) >>> (FRAC_BITS + 1));
			fac    = coef[REG_FACTOR_X + (f.dir >> 1)];
			pdrift = qmul(qmul(hdb, longint'(f.pos_n) + longint'(f.pos_c)), de);
			ndrift = qmul(qmul(hdb, longint'(f.neg_n) + longint'(f.neg_c)), de);
			pflux  = clip_mid(qmul(coef[REG_DIFFUSIVITY],
				longint'(f.pos_n) - longint'(f.pos_c)) + pdrift);
			nflux  = clip_mid(qmul(coef[REG_DIFFUSIVITY],
				longint'(f.neg_n) - longint'(f.neg_c)) - ndrift);
			pos_acc = acc_add(pos_acc, (fac * pflux) >>> FRAC_BITS);
			neg_acc = acc_add(neg_acc, (fac * nflux) >>> FRAC_BITS);
		end
		if (f.last) begin
			pr = 0;
			nr = 0;
			r.sat = 1'b0;
			if (f.in_mat) begin
				pr = clip_mid(pos_acc);
				nr = clip_mid(neg_acc);
				r.sat = (pr != pos_acc) || (nr != neg_acc);
			end
			r.pos_rate = pr[31:0];
			r.neg_rate = nr[31:0];
			rates_q.push_back(r);
			pos_acc = 0;
			neg_acc = 0;
		end
	endtask

	function automatic face_t mk_face(input face_dir_e dir, input logic blocked,
		input logic in_mat, input logic last, input logic [31:0] ec, input logic [31:0] en,
		input logic [31:0] pc, input logic [31:0] pn, input logic [31:0] nc,
		input logic [31:0] nn);
		face_t f;
		f.dir     = dir;
		f.blocked = blocked;
		f.in_mat  = in_mat;
		f.last    = last;
		f.pot_c   = ec;
		f.pot_n   = en;
		f.pos_c   = pc;
		f.pos_n   = pn;
		f.neg_c   = nc;
		f.neg_n   = nn;
		return f;
	endfunction

	// mostly small values, some extremes and some full-range words
	function automatic logic [31:0] rand_word();
		case ($urandom_range(15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	// coefficient between 0.25 and 4.0, top bit set at random
	function automatic logic [31:0] rand_coef();
		return 32'($urandom_range(32'h0000_4000, 32'h0004_0000)) | (32'($urandom_range(1)) << 31);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS) coef[idx] = longint'(val[REG_W-1:0]);
	endtask

	task automatic program_regs(input logic [31:0] d, input logic [31:0] b,
		input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz, input bit spare);
		write_reg(REG_DIFFUSIVITY, d);
		write_reg(REG_BETA, b);
		write_reg(REG_FACTOR_X, fx);
		write_reg(REG_FACTOR_Y, fy);
		write_reg(REG_FACTOR_Z, fz);
		// unmapped indexes must leave the registers alone
		if (spare) begin
			for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++) write_reg(CFG_IDX_W'(k), $urandom);
		end
		cfg_valid <= 1'b0;
	endtask

	// wait for the phase to finish, then let the block settle
	task automatic drain();
		int waited;
		waited = 0;
		while ((faces_q.size() != 0 || s_axis_tvalid || rates_q.size() != 0)
			&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (faces_q.size() != 0 || s_axis_tvalid || rates_q.size() != 0) begin
			$error("stalled with %0d faces and %0d results outstanding",
				faces_q.size(), rates_q.size());
			errors++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// face driver: next transfer once the current one is taken
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) accumulate_face(cur_face);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (faces_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_face = faces_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {cur_face.neg_n, cur_face.neg_c, cur_face.pos_n,
					cur_face.pos_c, cur_face.pot_n, cur_face.pot_c};
				s_axis_tuser  <= {cur_face.in_mat, cur_face.blocked, cur_face.dir};
				s_axis_tlast  <= cur_face.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, one long hold-off when armed
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor: compare each transfer with the oldest expected rates
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (rates_q.size() == 0) begin
				$error("unexpected result: pos_rate %0d neg_rate %0d saturated %0d",
					$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]), m_axis_tuser[0]);
				errors++;
			end else begin
				head_rates = rates_q.pop_front();
				if (m_axis_tdata[31:0] !== head_rates.pos_rate) begin
					$error("pos_rate: expected %0d, got %0d",
						head_rates.pos_rate, $signed(m_axis_tdata[31:0]));
					errors++;
				end
				if (m_axis_tdata[63:32] !== head_rates.neg_rate) begin
					$error("neg_rate: expected %0d, got %0d",
						head_rates.neg_rate, $signed(m_axis_tdata[63:32]));
					errors++;
				end
				if (m_axis_tuser[0] !== head_rates.sat) begin
					$error("saturated: expected %0d, got %0d", head_rates.sat, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	// main sequence: reset, directed cells, then random phases
	initial begin
		int queued, len, rot;
		logic mat;
		for (int i = 0; i < NUM_REGS; i++) coef[i] = longint'(REG_RESET);
		pos_acc = 0;
		neg_acc = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// single-face cell of zeros
		faces_q.push_back(mk_face(FACE_XP, 1'b0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0));
		// ordinary cell over all six faces
		for (int k = 0; k < 6; k++) begin
			faces_q.push_back(mk_face(face_dir_e'(k), 1'b0, 1'b1, k == 5, 32'h0000_8000,
				32'h0002_0000, 32'h0001_0000 + (k << 12), 32'h0003_0000, 32'hFFFF_0000,
				32'h0000_4000));
		end
		// extreme operands, rates clip
		for (int k = 0; k < 6; k++) begin
			faces_q.push_back(mk_face(face_dir_e'(k), 1'b0, 1'b1, k == 5, 32'h8000_0000,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		end
		// blocked face carries nothing
		faces_q.push_back(mk_face(FACE_ZN, 1'b1, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		faces_q.push_back(mk_face(FACE_YP, 1'b0, 1'b1, 1'b1, 32'h0001_0000, 32'h0000_0000,
			32'h0002_0000, 32'h0001_8000, 32'h0000_c000, 32'h0001_0000));
		// invalid directions carry nothing
		faces_q.push_back(mk_face(FACE_BAD6, 1'b0, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		faces_q.push_back(mk_face(FACE_BAD7, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		// cell outside the material reads as zero
		faces_q.push_back(mk_face(FACE_XN, 1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		faces_q.push_back(mk_face(FACE_XP, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// register settings: unity, all ones, zero, then random
			case (ph)
				0: program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
					32'h0001_0000, 1'b1);
				1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 1'b0);
				2: program_regs('0, '0, '0, '0, '0, 1'b0);
				4: program_regs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
				default: program_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), 1'b0);
			endcase
			send_idle_pct  = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			if (ph == 3) hold_arm = 1'b1;

			// mostly whole six-face cells, the rest odd-length noise
			queued = 0;
			while (queued < PHASE_FACES) begin
				if ($urandom_range(99) < 85) begin
					rot = $urandom_range(5);
					mat = ($urandom_range(99) < 85);
					for (int k = 0; k < 6; k++) begin
						faces_q.push_back(mk_face(face_dir_e'((k + rot) % 6),
							$urandom_range(99) < 15, mat, k == 5, rand_word(), rand_word(),
							rand_word(), rand_word(), rand_word(), rand_word()));
					end
					queued += 6;
				end else begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++) begin
						faces_q.push_back(mk_face(face_dir_e'($urandom_range(7)),
							1'($urandom_range(1)), 1'($urandom_range(1)), k == len - 1,
							rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
							rand_word()));
					end
					queued += len;
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#(CLK_PERIOD * RUN_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
